### rtl/sis_pkg.sv
// ----------------------------------------------------------------------------
// sis_pkg: shared types and constants of the sorted integer set
// Request kinds, status codes and the control word broadcast to every cell.
// ----------------------------------------------------------------------------
`default_nettype none

package sis_pkg;

    localparam int CAPACITY_DEF = 16;   // entries held by default
    localparam int WORD_W       = 32;   // element width
    localparam int POS_W        = 4;    // position field width
    localparam int COUNT_W      = 5;    // reported count width
    localparam int STATUS_W     = 3;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_DEL   = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_READ  = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_DUP    = 3'd1,
        ST_FULL   = 3'd2,
        ST_ABSENT = 3'd3,
        ST_RANGE  = 3'd4
    } t_status;

    // Broadcast to all cells for one request.
    typedef struct packed {
        logic  ins;     // insert value at its sorted slot
        logic  del;     // remove the entry at the slot
        t_word value;   // request value
    } t_cell_ctl;

endpackage

`default_nettype wire

### rtl/sis_cell.sv
// ----------------------------------------------------------------------------
// sis_cell: one slot of the sorted chain
// Holds one entry, compares it with the request value and on a change loads
// from its left neighbor (insert), its right neighbor (remove) or the value.
// ----------------------------------------------------------------------------
`default_nettype none

module sis_cell
    import sis_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int IDX      = 0,
    localparam int CW      = $clog2(CAPACITY + 1)
) (
    input  wire logic          i_clk,
    input  wire t_cell_ctl     i_ctl,
    input  wire logic [CW-1:0] i_count,
    input  wire t_word         i_left_entry,
    input  wire logic          i_left_lt,      // left neighbor holds a smaller value
    input  wire t_word         i_right_entry,
    output t_word              o_entry,
    output logic               o_lt,           // valid and entry < value
    output logic               o_eq            // valid and entry == value
);

    t_word r_entry;
    t_word n_entry;
    logic  w_valid;

    assign w_valid = (i_count > CW'(IDX));
    assign o_lt    = w_valid && (r_entry < i_ctl.value);
    assign o_eq    = w_valid && (r_entry == i_ctl.value);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins && !o_lt) begin
            // slot cell takes the value, cells past it shift up
            n_entry = i_left_lt ? i_ctl.value : i_left_entry;
        end else if (i_ctl.del && !o_lt) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

### rtl/sorted_integer_set.sv
// ----------------------------------------------------------------------------
// sorted_integer_set: ordered set of distinct signed 32-bit integers
// A row of compare-and-shift cells keeps up to CAPACITY values ascending.
// ----------------------------------------------------------------------------
// Usage:
//   Requests come in on the s_axis channel: tuser carries the request kind
//   (add, remove, query, read position), tdata the value and the position.
//   Each request yields exactly one result on m_axis: tuser carries the
//   presence flag and status, tdata the count after the request and the
//   element read (zero unless a read succeeds).
//   All cells compare against the request value in parallel; the slot is
//   where the "smaller than value" flags end. Insert shifts cells at and past
//   the slot up by one, remove shifts them down by one, all at the accepting edge.
//   The result is registered at the edge that accepts the request.
//   Throughput: one request per cycle; the next request is taken in the same
//   cycle the previous result is taken, set by the single output register.
//   When the receiver stalls, the result holds and s_axis_tready drops until
//   the result is taken.
//   Reset (i_rst_n low, synchronous) empties the set and drops any pending
//   result; s_axis_tready stays low while reset is held. Entry contents are
//   not cleared, the count alone marks them valid.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_integer_set
    import sis_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // [31:0] value, [35:32] position, pad
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [4:0] count, [36:5] element, pad
    output logic [3:0]       m_axis_tuser    // [0] present, [3:1] status
);

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int PW  = (CW > POS_W) ? CW : POS_W;
    localparam int RDN = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);

    // request fields
    t_req              w_req;
    t_word             w_value;
    logic [POS_W-1:0]  w_pos;
    logic              w_accept;

    // cell row
    t_cell_ctl         w_ctl;
    t_word             w_entry [CAPACITY];
    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY-1:0] w_eq;

    logic              w_held;
    logic              w_full;
    logic              w_rd_ok;
    t_word             w_rd_entry;

    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    t_status           n_status;
    t_word             n_elem;

    logic              r_out_valid;
    logic              r_present;
    t_status           r_status;
    logic [COUNT_W-1:0] r_count_out;
    t_word             r_elem;

    assign w_req   = t_req'(s_axis_tuser);
    assign w_value = s_axis_tdata[WORD_W-1:0];
    assign w_pos   = s_axis_tdata[WORD_W+POS_W-1:WORD_W];

    // one output register: free when empty or being drained
    assign s_axis_tready = i_rst_n && (!r_out_valid || m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_held = |w_eq;
    assign w_full = (r_count == CW'(CAPACITY));
    assign w_rd_ok = (PW'(w_pos) < PW'(r_count));

    // position mux over the readable cells
    always_comb begin
        w_rd_entry = '0;
        for (int i = 0; i < RDN; i++) begin
            if (w_pos == POS_W'(i)) begin
                w_rd_entry = w_entry[i];
            end
        end
    end

    // request decode
    always_comb begin
        w_ctl.ins   = 1'b0;
        w_ctl.del   = 1'b0;
        w_ctl.value = w_value;
        n_count     = r_count;
        n_status    = ST_OK;
        n_elem      = '0;
        unique case (w_req)
            REQ_ADD: begin
                if (w_held) begin
                    n_status = ST_DUP;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctl.ins = w_accept;
                    n_count   = r_count + CW'(1);
                end
            end
            REQ_DEL: begin
                if (!w_held) begin
                    n_status = ST_ABSENT;
                end else begin
                    w_ctl.del = w_accept;
                    n_count   = r_count - CW'(1);
                end
            end
            REQ_QUERY: begin
                n_status = ST_OK;
            end
            REQ_READ: begin
                if (w_rd_ok) begin
                    n_elem = w_rd_entry;
                end else begin
                    n_status = ST_RANGE;
                end
            end
        endcase
    end

    // cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_word w_left;
        t_word w_right;
        logic  w_left_lt;

        if (g == 0) begin : g_first
            assign w_left    = '0;
            assign w_left_lt = 1'b1;   // head cell is the slot once it is not smaller
        end else begin : g_mid
            assign w_left    = w_entry[g-1];
            assign w_left_lt = w_lt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_entry[g+1];
        end

        sis_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_count       (r_count),
            .i_left_entry  (w_left),
            .i_left_lt     (w_left_lt),
            .i_right_entry (w_right),
            .o_entry       (w_entry[g]),
            .o_lt          (w_lt[g]),
            .o_eq          (w_eq[g])
        );
    end

    // fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            r_count <= n_count;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_present   <= w_held;
            r_status    <= n_status;
            r_count_out <= COUNT_W'(n_count);
            r_elem      <= n_elem;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_elem, r_count_out};
    assign m_axis_tuser  = {r_status, r_present};

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("fill count above capacity");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (w_req == REQ_ADD) && !w_held && !w_full
        |=> r_count == $past(r_count) + CW'(1))
        else $error("successful add did not grow the set");

    a_query_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && ((w_req == REQ_QUERY) || (w_req == REQ_READ))
        |=> r_count == $past(r_count))
        else $error("lookup changed the count");

    a_elem_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_status != ST_OK) |-> r_elem == '0)
        else $error("element set on a failed request");

endmodule

`default_nettype wire
